FILE: sv/sdsc_pkg.sv
// Shared types and constants for the staged docking steering control.
// Holds phase/status codes, config register indexes and inter-stage structs.
// No dependencies.
package sdsc_pkg;

  localparam int QW = 12;

  localparam logic signed [16:0] Q_PI     = 17'sd12868;
  localparam logic signed [16:0] Q_TWO_PI = 17'sd25736;
  localparam logic signed [27:0] Q_HALF   = 28'sd2048;

  typedef enum logic [1:0] {
    PH_APPROACH = 2'd0,
    PH_FINAL    = 2'd1,
    PH_ALIGNED  = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_APPROACH    = 3'd0,
    ST_FINAL       = 3'd1,
    ST_ALIGNED     = 3'd2,
    ST_TIMEOUT     = 3'd3,
    ST_NO_DATA     = 3'd4,
    ST_ENTER_FINAL = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    LIN_ZERO     = 2'd0,
    LIN_FINAL    = 2'd1,
    LIN_APPROACH = 2'd2
  } lin_sel_t;

  localparam logic [2:0] REG_FINAL_DISTANCE = 3'd0;
  localparam logic [2:0] REG_FINAL_SPEED    = 3'd1;
  localparam logic [2:0] REG_FORWARD_GAIN   = 3'd2;
  localparam logic [2:0] REG_SPEED_LIMIT    = 3'd3;
  localparam logic [2:0] REG_HEADING_GAIN   = 3'd4;
  localparam logic [2:0] REG_RATE_GAIN      = 3'd5;
  localparam logic [2:0] REG_TURN_LIMIT     = 3'd6;
  localparam logic [2:0] REG_FINAL_TICKS    = 3'd7;

  typedef struct packed {
    logic [22:0] final_distance;
    logic [14:0] final_speed;
    logic [15:0] forward_gain;
    logic [14:0] speed_limit;
    logic [15:0] heading_gain;
    logic [15:0] rate_gain;
    logic [14:0] turn_limit;
    logic [15:0] final_ticks;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    final_distance: 23'd4096,
    final_speed:    15'd1229,
    forward_gain:   16'd1638,
    speed_limit:    15'd1638,
    heading_gain:   16'd6144,
    rate_gain:      16'd819,
    turn_limit:     15'd3277,
    final_ticks:    16'd87
  };

  // Decision stage -> multiply stage
  typedef struct packed {
    logic               cmd_valid;
    lin_sel_t           lin_sel;
    logic               steer;
    status_t            status;
    phase_t             phase;
    logic signed [15:0] herr;
    logic signed [15:0] rate;
    logic [22:0]        dy;
  } dec_t;

  // Multiply stage -> output stage
  typedef struct packed {
    logic               cmd_valid;
    lin_sel_t           lin_sel;
    logic               steer;
    status_t            status;
    phase_t             phase;
    logic signed [15:0] herr;
    logic signed [32:0] prod_h;
    logic signed [32:0] prod_r;
    logic [38:0]        prod_f;
  } prod_t;

endpackage

FILE: sv/sdsc_ctrl.sv
// Decision stage: holds the pose sample, silence and final counters and phase.
// Updates all state on each input transfer. Depends on sdsc_pkg.
module sdsc_ctrl #(
  parameter int TIMEOUT_TICKS = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sdsc_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_fresh,
  input  logic signed [23:0] in_pos_y,
  input  logic signed [14:0] in_heading,
  input  logic signed [15:0] in_yaw_rate,
  output logic               dec_valid,
  input  logic               dec_ready,
  output sdsc_pkg::dec_t     dec
);
  import sdsc_pkg::*;

  localparam logic [15:0] TIMEOUT_LIM = 16'(TIMEOUT_TICKS);

  phase_t             phase_r, phase_nxt;
  logic               data_ok_r, data_ok_nxt;
  logic               seen_r, seen_nxt;
  logic signed [23:0] held_y_r, y_now;
  logic signed [14:0] held_h_r, h_now;
  logic signed [15:0] held_rate_r, rate_now;
  logic signed [14:0] locked_r, locked_nxt;
  logic [15:0]        fcount_r, fcount_nxt, fcount_inc;
  logic [15:0]        silence_r, silence_nxt;
  logic               valid_r;
  dec_t               dec_r, dec_nxt;
  logic               accept, timeout;
  logic signed [16:0] diff_fin, diff_app;
  logic signed [24:0] dy_full;

  function automatic logic signed [15:0] wrap(input logic signed [16:0] a);
    logic signed [16:0] r;
    if (a > Q_PI)       r = a - Q_TWO_PI;
    else if (a < -Q_PI) r = a + Q_TWO_PI;
    else                r = a;
    return r[15:0];
  endfunction

  assign in_ready = !valid_r || dec_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    y_now    = in_fresh ? in_pos_y    : held_y_r;
    h_now    = in_fresh ? in_heading  : held_h_r;
    rate_now = in_fresh ? in_yaw_rate : held_rate_r;
    seen_nxt = seen_r || in_fresh;
    if (in_fresh)                silence_nxt = '0;
    else if (silence_r != '1)    silence_nxt = silence_r + 16'd1;
    else                         silence_nxt = silence_r;
    if (phase_r == PH_FINAL && fcount_r != '1) fcount_inc = fcount_r + 16'd1;
    else                                        fcount_inc = fcount_r;
    timeout  = seen_nxt && (silence_nxt > TIMEOUT_LIM);
    diff_fin = 17'(locked_r) - 17'(h_now);
    diff_app = 17'sd0 - 17'(h_now);
    dy_full  = 25'(y_now) - $signed({2'b00, cfg.final_distance});

    phase_nxt   = phase_r;
    data_ok_nxt = data_ok_r || in_fresh;
    locked_nxt  = locked_r;
    fcount_nxt  = fcount_inc;

    dec_nxt           = '0;
    dec_nxt.lin_sel   = LIN_ZERO;
    dec_nxt.status    = ST_NO_DATA;
    dec_nxt.rate      = rate_now;
    dec_nxt.dy        = dy_full[22:0];

    if (timeout) begin
      dec_nxt.cmd_valid = 1'b1;
      dec_nxt.status    = ST_TIMEOUT;
      data_ok_nxt       = 1'b0;
    end else if (!data_ok_nxt) begin
      dec_nxt.status = ST_NO_DATA;
    end else begin
      unique case (phase_r)
        PH_FINAL: begin
          if (fcount_inc >= cfg.final_ticks) begin
            phase_nxt         = PH_ALIGNED;
            dec_nxt.cmd_valid = 1'b1;
            dec_nxt.status    = ST_ALIGNED;
          end else begin
            dec_nxt.cmd_valid = 1'b1;
            dec_nxt.status    = ST_FINAL;
            dec_nxt.steer     = 1'b1;
            dec_nxt.herr      = wrap(diff_fin);
            dec_nxt.lin_sel   = LIN_FINAL;
          end
        end
        PH_ALIGNED: begin
          dec_nxt.cmd_valid = 1'b1;
          dec_nxt.status    = ST_ALIGNED;
        end
        default: begin
          if (y_now <= $signed({1'b0, cfg.final_distance})) begin
            phase_nxt      = PH_FINAL;
            locked_nxt     = h_now;
            fcount_nxt     = '0;
            dec_nxt.status = ST_ENTER_FINAL;
          end else begin
            dec_nxt.cmd_valid = 1'b1;
            dec_nxt.status    = ST_APPROACH;
            dec_nxt.steer     = 1'b1;
            dec_nxt.herr      = wrap(diff_app);
            dec_nxt.lin_sel   = LIN_APPROACH;
          end
        end
      endcase
    end
    dec_nxt.phase = phase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_APPROACH;
      data_ok_r   <= 1'b0;
      seen_r      <= 1'b0;
      held_y_r    <= '0;
      held_h_r    <= '0;
      held_rate_r <= '0;
      locked_r    <= '0;
      fcount_r    <= '0;
      silence_r   <= '0;
      valid_r     <= 1'b0;
    end else begin
      if (accept) begin
        phase_r     <= phase_nxt;
        data_ok_r   <= data_ok_nxt;
        seen_r      <= seen_nxt;
        held_y_r    <= y_now;
        held_h_r    <= h_now;
        held_rate_r <= rate_now;
        locked_r    <= locked_nxt;
        fcount_r    <= fcount_nxt;
        silence_r   <= silence_nxt;
      end
      if (in_ready) valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) dec_r <= dec_nxt;
  end

  assign dec_valid = valid_r;
  assign dec       = dec_r;

endmodule

FILE: sv/sdsc_mult.sv
// Multiply stage: heading P, yaw-rate D and distance-to-speed products.
// Depends on sdsc_pkg.
module sdsc_mult (
  input  logic           clk,
  input  logic           rst_n,
  input  sdsc_pkg::cfg_t cfg,
  input  logic           dec_valid,
  output logic           dec_ready,
  input  sdsc_pkg::dec_t dec,
  output logic           prod_valid,
  input  logic           prod_ready,
  output sdsc_pkg::prod_t prod
);
  import sdsc_pkg::*;

  logic  valid_r;
  prod_t prod_r, prod_nxt;

  assign dec_ready = !valid_r || prod_ready;

  always_comb begin
    prod_nxt.cmd_valid = dec.cmd_valid;
    prod_nxt.lin_sel   = dec.lin_sel;
    prod_nxt.steer     = dec.steer;
    prod_nxt.status    = dec.status;
    prod_nxt.phase     = dec.phase;
    prod_nxt.herr      = dec.herr;
    prod_nxt.prod_h    = $signed({1'b0, cfg.heading_gain}) * dec.herr;
    prod_nxt.prod_r    = $signed({1'b0, cfg.rate_gain}) * dec.rate;
    prod_nxt.prod_f    = 39'(cfg.forward_gain) * 39'(dec.dy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (dec_ready) begin
      valid_r <= dec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dec_valid && dec_ready) prod_r <= prod_nxt;
  end

  assign prod_valid = valid_r;
  assign prod       = prod_r;

endmodule

FILE: sv/sdsc_out.sv
// Output stage: round Q.24 products to Q.12, clamp, and register the result.
// Depends on sdsc_pkg.
module sdsc_out (
  input  logic               clk,
  input  logic               rst_n,
  input  sdsc_pkg::cfg_t     cfg,
  input  logic               prod_valid,
  output logic               prod_ready,
  input  sdsc_pkg::prod_t    prod,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_cmd_valid,
  output logic [14:0]        out_linear_cmd,
  output logic signed [15:0] out_angular_cmd,
  output logic [1:0]         out_phase,
  output logic [2:0]         out_status,
  output logic signed [15:0] out_heading_error
);
  import sdsc_pkg::*;

  logic               valid_r;
  logic               cmd_valid_r;
  logic [14:0]        lin_r, lin_nxt;
  logic signed [15:0] ang_r, ang_nxt;
  logic [1:0]         phase_r;
  logic [2:0]         status_r;
  logic signed [15:0] herr_r;
  logic signed [33:0] pd_sum;
  logic signed [33:0] pd_round;
  logic signed [21:0] turn_q;
  logic signed [21:0] turn_lim;
  logic [39:0]        sp_round;
  logic [27:0]        sp_q;

  assign prod_ready = !valid_r || out_ready;

  always_comb begin
    pd_sum   = 34'(prod.prod_h) - 34'(prod.prod_r);
    pd_round = pd_sum + 34'(Q_HALF);
    turn_q   = 22'(pd_round >>> QW);
    turn_lim = 22'(cfg.turn_limit);
    if (turn_q > turn_lim)       ang_nxt = 16'(turn_lim);
    else if (turn_q < -turn_lim) ang_nxt = 16'(-turn_lim);
    else                         ang_nxt = 16'(turn_q);
    if (!prod.steer) ang_nxt = '0;

    sp_round = 40'(prod.prod_f) + 40'd2048;
    sp_q     = 28'(sp_round >> QW);
    case (prod.lin_sel)
      LIN_FINAL:    lin_nxt = cfg.final_speed;
      LIN_APPROACH: lin_nxt = (sp_q > 28'(cfg.speed_limit)) ? cfg.speed_limit
                                                             : sp_q[14:0];
      default:      lin_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (prod_ready) begin
      valid_r <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_valid && prod_ready) begin
      cmd_valid_r <= prod.cmd_valid;
      lin_r       <= lin_nxt;
      ang_r       <= ang_nxt;
      phase_r     <= prod.phase;
      status_r    <= prod.status;
      herr_r      <= prod.herr;
    end
  end

  assign out_valid         = valid_r;
  assign out_cmd_valid     = cmd_valid_r;
  assign out_linear_cmd    = lin_r;
  assign out_angular_cmd   = ang_r;
  assign out_phase         = phase_r;
  assign out_status        = status_r;
  assign out_heading_error = herr_r;

endmodule

FILE: sv/staged_docking_steering_control.sv
// Staged docking steering control, top level: config registers and 3-stage pipeline.
// An input transfer loads the first of three register stages (decision, multiply,
// output); the result is registered in the output stage. Throughput: one item per
// cycle while the result side does not stall, set by the decision-stage state update.
// Reset (rst_n low, synchronous): approach phase, counters and held sample cleared,
// config registers back to defaults, pipeline emptied. Depends on sdsc_pkg and stages.
module staged_docking_steering_control #(
  parameter int TIMEOUT_TICKS = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [22:0]        cfg_data,
  // input channel: one control tick per transfer
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_fresh,
  input  logic signed [23:0] in_pos_y,
  input  logic signed [14:0] in_heading,
  input  logic signed [15:0] in_yaw_rate,
  // result channel: one command per tick
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_cmd_valid,
  output logic [14:0]        out_linear_cmd,
  output logic signed [15:0] out_angular_cmd,
  output logic [1:0]         out_phase,
  output logic [2:0]         out_status,
  output logic signed [15:0] out_heading_error
);
  import sdsc_pkg::*;

  cfg_t  cfg_r;
  logic  dec_valid, dec_ready;
  dec_t  dec;
  logic  prod_valid, prod_ready;
  prod_t prod;

  // Always taken; user must let writes arrive only while the block is idle (unchecked).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FINAL_DISTANCE: cfg_r.final_distance <= cfg_data;
        REG_FINAL_SPEED:    cfg_r.final_speed    <= cfg_data[14:0];
        REG_FORWARD_GAIN:   cfg_r.forward_gain   <= cfg_data[15:0];
        REG_SPEED_LIMIT:    cfg_r.speed_limit    <= cfg_data[14:0];
        REG_HEADING_GAIN:   cfg_r.heading_gain   <= cfg_data[15:0];
        REG_RATE_GAIN:      cfg_r.rate_gain      <= cfg_data[15:0];
        REG_TURN_LIMIT:     cfg_r.turn_limit     <= cfg_data[14:0];
        REG_FINAL_TICKS:    cfg_r.final_ticks    <= cfg_data[15:0];
        default:            cfg_r                <= cfg_r;
      endcase
    end
  end

  // Stage 1: fold in the fresh sample, advance counters and phase, pick the
  // command kind and the wrapped heading error. All state settles here, so
  // the next tick can be taken straight away unless the later stages stall.
  sdsc_ctrl #(
    .TIMEOUT_TICKS(TIMEOUT_TICKS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_fresh   (in_fresh),
    .in_pos_y   (in_pos_y),
    .in_heading (in_heading),
    .in_yaw_rate(in_yaw_rate),
    .dec_valid  (dec_valid),
    .dec_ready  (dec_ready),
    .dec        (dec)
  );

  // Stage 2: the three gain products, each a single multiplier.
  sdsc_mult u_mult (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec       (dec),
    .prod_valid(prod_valid),
    .prod_ready(prod_ready),
    .prod      (prod)
  );

  // Stage 3: round half up to Q4.12, clamp turn and speed, hold the result
  // until the transfer on the result channel.
  sdsc_out u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .prod_valid       (prod_valid),
    .prod_ready       (prod_ready),
    .prod             (prod),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_cmd_valid    (out_cmd_valid),
    .out_linear_cmd   (out_linear_cmd),
    .out_angular_cmd  (out_angular_cmd),
    .out_phase        (out_phase),
    .out_status       (out_status),
    .out_heading_error(out_heading_error)
  );

endmodule

FILE: verif/tb_staged_docking_steering_control.sv
// Self-checking testbench for staged_docking_steering_control: random and directed control
// ticks, config writes between phases, commands predicted and checked in a scoreboard class.
// Depends on sdsc_pkg and the RTL of the block only.
module tb_staged_docking_steering_control;
  timeunit 1ns;
  timeprecision 1ps;
  import sdsc_pkg::*;

  localparam int SILENCE_LIMIT   = 10;      // ticks of silence tolerated before a stop
  localparam int WATCHDOG_LIMIT  = 1000;    // cycles without any transfer before giving up
  localparam int HOLD_OFF_CYCLES = 48;      // long result-side stall, fills the pipeline
  localparam int DRAIN_CYCLES    = 6;       // pipeline is 3 deep, leave some margin
  localparam int Y_MAX           = 8388607;

  // One expected command, laid out like the result channel
  typedef struct packed {
    logic               cmd_valid;
    logic [14:0]        linear;
    logic signed [15:0] angular;
    phase_t             phase;
    status_t            status;
    logic signed [15:0] herr;
  } cmd_t;

  // Scoreboard: mirrors the controller state, turns each accepted tick into the command
  // it must produce, and checks commands in order as they leave the block.
  class steer_scoreboard;
    cfg_t   cfg            = CFG_RESET;
    phase_t cur_phase      = PH_APPROACH;
    bit     data_ok        = 1'b0;
    bit     seen_data      = 1'b0;
    int     held_y         = 0;
    int     held_heading   = 0;
    int     held_rate      = 0;
    int     locked_heading = 0;
    int     final_count    = 0;
    int     silence_count  = 0;
    cmd_t   expected_cmds[$];
    int     mismatches     = 0;

    function void set_reg(logic [2:0] idx, logic [22:0] d);
      case (idx)
        REG_FINAL_DISTANCE: cfg.final_distance = d;
        REG_FINAL_SPEED:    cfg.final_speed    = d[14:0];
        REG_FORWARD_GAIN:   cfg.forward_gain   = d[15:0];
        REG_SPEED_LIMIT:    cfg.speed_limit    = d[14:0];
        REG_HEADING_GAIN:   cfg.heading_gain   = d[15:0];
        REG_RATE_GAIN:      cfg.rate_gain      = d[15:0];
        REG_TURN_LIMIT:     cfg.turn_limit     = d[14:0];
        REG_FINAL_TICKS:    cfg.final_ticks    = d[15:0];
        default: ;
      endcase
    endfunction

    // Q.24 product back to Q.12, round half up
    function longint round_q12(longint v);
      return (v + 2048) >>> 12;
    endfunction

    // single 2pi correction only
    function int wrap_pi(int a);
      if (a > Q_PI) return a - Q_TWO_PI;
      if (a < -Q_PI) return a + Q_TWO_PI;
      return a;
    endfunction

    // PD turn command, clamped symmetrically
    function int steer_cmd(int err);
      longint v, lim;
      v = longint'(cfg.heading_gain) * err - longint'(cfg.rate_gain) * held_rate;
      v = round_q12(v);
      lim = cfg.turn_limit;
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      return int'(v);
    endfunction

    function cmd_t predict_command(logic fresh, logic signed [23:0] y,
                                   logic signed [14:0] h, logic signed [15:0] r);
      cmd_t   c;
      int     fd, err;
      longint sp;
      c = '0;
      if (cur_phase == PH_FINAL && final_count < 65535) final_count++;
      if (fresh) begin
        held_y        = y;
        held_heading  = h;
        held_rate     = r;
        data_ok       = 1'b1;
        seen_data     = 1'b1;
        silence_count = 0;
      end else if (silence_count < 65535) begin
        silence_count++;
      end

      if (seen_data && silence_count > SILENCE_LIMIT) begin
        c.cmd_valid = 1'b1;
        c.status    = ST_TIMEOUT;
        data_ok     = 1'b0;
      end else if (!data_ok) begin
        c.status = ST_NO_DATA;
      end else if (cur_phase == PH_FINAL) begin
        if (final_count >= int'(cfg.final_ticks)) begin
          cur_phase   = PH_ALIGNED;
          c.cmd_valid = 1'b1;
          c.status    = ST_ALIGNED;
        end else begin
          err         = wrap_pi(locked_heading - held_heading);
          c.herr      = 16'(err);
          c.angular   = 16'(steer_cmd(err));
          c.linear    = cfg.final_speed;
          c.cmd_valid = 1'b1;
          c.status    = ST_FINAL;
        end
      end else if (cur_phase == PH_ALIGNED) begin
        c.cmd_valid = 1'b1;
        c.status    = ST_ALIGNED;
      end else begin
        fd = cfg.final_distance;
        if (held_y <= fd) begin
          cur_phase      = PH_FINAL;
          locked_heading = held_heading;
          final_count    = 0;
          c.status       = ST_ENTER_FINAL;
        end else begin
          err       = wrap_pi(-held_heading);
          c.herr    = 16'(err);
          c.angular = 16'(steer_cmd(err));
          sp = round_q12(longint'(cfg.forward_gain) * (held_y - fd));
          if (sp < 0) sp = 0;
          if (sp > longint'(cfg.speed_limit)) sp = cfg.speed_limit;
          c.linear    = 15'(sp);
          c.cmd_valid = 1'b1;
          c.status    = ST_APPROACH;
        end
      end
      c.phase = cur_phase;
      return c;
    endfunction

    function void note_tick(logic fresh, logic signed [23:0] y,
                            logic signed [14:0] h, logic signed [15:0] r);
      expected_cmds.push_back(predict_command(fresh, y, h, r));
    endfunction

    function void check_result(logic v, logic [14:0] lin, logic signed [15:0] ang,
                               logic [1:0] ph, logic [2:0] st, logic signed [15:0] herr);
      cmd_t want;
      bit   bad;
      if (expected_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] command with no tick pending: status=%0d phase=%0d", $time, st, ph);
        return;
      end
      want = expected_cmds.pop_front();
      bad = (v !== want.cmd_valid) || (lin !== want.linear) || (ang !== want.angular) ||
            (ph !== want.phase) || (st !== want.status) || (herr !== want.herr);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"[%0t] command mismatch: expected valid=%0d lin=%0d ang=%0d phase=%0d ",
                    "status=%0d herr=%0d, got valid=%0d lin=%0d ang=%0d phase=%0d status=%0d ",
                    "herr=%0d"}, $time, want.cmd_valid, want.linear, want.angular,
                   want.phase, want.status, want.herr, v, lin, ang, ph, st, herr);
      end
    endfunction
  endclass

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [22:0]        cfg_data  = '0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic               in_fresh  = 1'b0;
  logic signed [23:0] in_pos_y  = '0;
  logic signed [14:0] in_heading  = '0;
  logic signed [15:0] in_yaw_rate = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_cmd_valid;
  logic [14:0]        out_linear_cmd;
  logic signed [15:0] out_angular_cmd;
  logic [1:0]         out_phase;
  logic [2:0]         out_status;
  logic signed [15:0] out_heading_error;

  steer_scoreboard sb = new();

  int ticks_sent = 0;   // tick transfers so far, paces the sender's idle stretches
  int rush_left  = 0;   // ticks still to be offered back to back
  bit hold_req   = 1'b0; // ask the result side for one long stall

  staged_docking_steering_control #(
    .TIMEOUT_TICKS(SILENCE_LIMIT)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_fresh          (in_fresh),
    .in_pos_y          (in_pos_y),
    .in_heading        (in_heading),
    .in_yaw_rate       (in_yaw_rate),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_cmd_valid     (out_cmd_valid),
    .out_linear_cmd    (out_linear_cmd),
    .out_angular_cmd   (out_angular_cmd),
    .out_phase         (out_phase),
    .out_status        (out_status),
    .out_heading_error (out_heading_error)
  );

  always #10 clk = ~clk;

  // Monitors: sample the pre-edge values, so every transfer is seen exactly once.
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_tick(in_fresh, in_pos_y, in_heading, in_yaw_rate);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_cmd_valid, out_linear_cmd, out_angular_cmd, out_phase,
                      out_status, out_heading_error);
  end

  // Offer one tick and hold it until the transfer. Valid is dropped only when a gap is
  // drawn, so back-to-back ticks never lower and raise valid in the same step.
  task automatic send_tick(logic f, logic signed [23:0] y, logic signed [14:0] h,
                           logic signed [15:0] r);
    int gap;
    gap = (rush_left > 0 || (ticks_sent % 64) < 16) ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_fresh    <= f;
    in_pos_y    <= y;
    in_heading  <= h;
    in_yaw_rate <= r;
    do @(posedge clk); while (!in_ready);
    ticks_sent++;
    if (rush_left > 0) rush_left--;
  endtask

  // Random ticks. With keep_far the distance stays past the switch-over point, so the
  // approach law keeps running. Silent bursts long enough to trip the timeout are mixed in.
  task automatic random_ticks(int n, bit keep_far);
    int                 quiet_left, lo, pick;
    logic               f;
    logic signed [23:0] y;
    logic signed [14:0] h;
    logic signed [15:0] r;
    quiet_left = 0;
    lo = int'(sb.cfg.final_distance) + 1;
    for (int i = 0; i < n; i++) begin
      if (quiet_left == 0 && i > 0 && $urandom_range(0, 24) == 0)
        quiet_left = $urandom_range(SILENCE_LIMIT + 1, SILENCE_LIMIT + 4);
      // open with a fresh sample: a stale distance may sit under a new switch-over point
      if (i == 0) begin
        f = 1'b1;
      end else if (quiet_left > 0) begin
        f = 1'b0;
        quiet_left--;
      end else begin
        f = ($urandom_range(0, 6) != 0);
      end

      pick = $urandom_range(0, 7);
      if (keep_far) begin
        if (pick == 0) y = 24'(Y_MAX);
        else if (pick == 1) y = 24'(lo);
        else y = 24'(lo + int'($urandom % (Y_MAX + 1 - lo)));
      end else begin
        if (pick == 0) y = {1'b1, 23'd0};
        else if (pick == 1) y = {1'b0, {23{1'b1}}};
        else y = 24'($urandom);
      end

      case ($urandom_range(0, 7))
        0:       h = 15'h3FFF;
        1:       h = 15'h4000;
        2:       h = 15'(Q_PI);
        3:       h = 15'(-Q_PI);
        default: h = 15'($urandom);
      endcase

      case ($urandom_range(0, 7))
        0:       r = 16'h7FFF;
        1:       r = 16'h8000;
        default: r = 16'($urandom);
      endcase

      send_tick(f, y, h, r);
    end
  endtask

  // Drop valid, let every expected command come out, then give the pipeline time to settle.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_cmds.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all eight registers back to back; call only while the block is idle.
  task automatic load_config(logic [22:0] fd, logic [22:0] fs, logic [22:0] fg,
                             logic [22:0] sl, logic [22:0] hg, logic [22:0] rg,
                             logic [22:0] tl, logic [22:0] ft);
    logic [22:0] vals [8];
    vals[REG_FINAL_DISTANCE] = fd;
    vals[REG_FINAL_SPEED]    = fs;
    vals[REG_FORWARD_GAIN]   = fg;
    vals[REG_SPEED_LIMIT]    = sl;
    vals[REG_HEADING_GAIN]   = hg;
    vals[REG_RATE_GAIN]      = rg;
    vals[REG_TURN_LIMIT]     = tl;
    vals[REG_FINAL_TICKS]    = ft;
    for (int i = 0; i < 8; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // Result side: random stalls per command, quiet stretches with none, and one long
  // hold-off on request, counted here so the sender keeps pushing meanwhile.
  initial begin : result_sink
    int gap, taken;
    taken = 0;
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = ((taken % 50) < 12) ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // Watchdog: any transfer on any channel counts as progress.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[%0t] watchdog: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed ticks on the reset configuration.
    // No sample seen yet: no command at all, whatever the payload.
    send_tick(1'b0, 24'h7FFFFF, 15'h3FFF, 16'h7FFF);
    send_tick(1'b0, 24'h800000, 15'h4000, 16'h8000);
    send_tick(1'b0, 24'h000000, 15'h0000, 16'h0000);
    // Approach: far away saturates the speed clamp, extremes of heading and rate
    // push the turn command against its clamp in both directions.
    send_tick(1'b1, 24'(Y_MAX), 15'h0000, 16'h0000);
    send_tick(1'b1, 24'd4097, 15'h3FFF, 16'h7FFF);
    send_tick(1'b1, 24'(Y_MAX), 15'h4000, 16'h8000);
    // Heading at plus and minus pi, and just beyond, where the error wraps by one turn.
    send_tick(1'b1, 24'd6000, 15'(Q_PI), 16'h0000);
    send_tick(1'b1, 24'd6000, 15'(-Q_PI), 16'h0000);
    send_tick(1'b1, 24'd6000, 15'(Q_PI + 1), 16'h0000);
    send_tick(1'b1, 24'd6000, 15'(-Q_PI - 1), 16'h0000);
    // Stale sample held, then silence until the timeout stop fires twice.
    repeat (SILENCE_LIMIT + 2)
      send_tick(1'b0, 24'($urandom), 15'($urandom), 16'($urandom));
    // Fresh data clears the timeout.
    send_tick(1'b1, 24'd100000, 15'd100, 16'hFF38);

    // Gains and limits at their maximum, switch-over at zero distance.
    drain();
    load_config(23'd0, 23'd32767, 23'd65535, 23'd32767, 23'd65535, 23'd65535,
                23'd32767, 23'd65535);
    random_ticks(30, 1'b1);
    // Stall the result side for a long stretch while ticks keep coming back to back.
    hold_req  = 1'b1;
    rush_left = 40;
    random_ticks(90, 1'b1);

    // Everything zero: commands collapse to zero, only the switch-over point is random.
    drain();
    load_config(23'($urandom_range(0, 1 << 22)), 23'd0, 23'd0, 23'd0, 23'd0, 23'd0,
                23'd0, 23'd0);
    random_ticks(100, 1'b1);

    // Random setting, still approaching.
    drain();
    load_config(23'($urandom_range(0, 1 << 22)), 23'($urandom_range(0, 32767)),
                23'($urandom_range(0, 65535)), 23'($urandom_range(0, 32767)),
                23'($urandom_range(0, 65535)), 23'($urandom_range(0, 65535)),
                23'($urandom_range(0, 32767)), 23'($urandom_range(0, 65535)));
    random_ticks(80, 1'b1);

    // Switch-over at the largest distance: enter the final phase exactly at the limit,
    // run the constant-speed ticks, then stay aligned for the rest of the run.
    drain();
    load_config(23'(Y_MAX), 23'($urandom_range(0, 32767)),
                23'($urandom_range(0, 65535)), 23'($urandom_range(0, 32767)),
                23'($urandom_range(0, 65535)), 23'($urandom_range(0, 65535)),
                23'($urandom_range(0, 32767)), 23'($urandom_range(15, 50)));
    send_tick(1'b1, 24'(Y_MAX), 15'($urandom), 16'($urandom));
    random_ticks(150, 1'b0);

    drain();
    if (sb.mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: sim.f
sv/sdsc_pkg.sv
sv/sdsc_ctrl.sv
sv/sdsc_mult.sv
sv/sdsc_out.sv
sv/staged_docking_steering_control.sv
verif/tb_staged_docking_steering_control.sv
